// ----- src/u16u8_pkg.sv -----
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8 transcoder.
// No dependencies; used by the controller, datapath and top level.
package u16u8_pkg;

	localparam int unsigned DEF_HEAD_WINDOW = 128;
	localparam int unsigned MIN_PAIRS       = 4;

	localparam logic [7:0]  BOM_FF    = 8'hFF;
	localparam logic [7:0]  BOM_FE    = 8'hFE;
	localparam logic [15:0] SURR_LO   = 16'hD800;
	localparam logic [15:0] SURR_HI   = 16'hDFFF;
	localparam logic [7:0]  LEAD2     = 8'hC0;
	localparam logic [7:0]  LEAD3     = 8'hE0;
	localparam logic [7:0]  CONT      = 8'h80;
	localparam logic [7:0]  QMARK     = 8'h3F;
	localparam logic [15:0] LIMIT_ONE = 16'h0080;
	localparam logic [15:0] LIMIT_TWO = 16'h0800;

	typedef enum logic [1:0] {
		ORD_UNDECIDED = 2'd0,
		ORD_LITTLE    = 2'd1,
		ORD_BIG       = 2'd2,
		ORD_NOT16     = 2'd3
	} order_t;

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_FRD  = 3'b010,
		ST_FOUT = 3'b100
	} state_t;

	// source of a result loaded into the output register
	typedef enum logic [1:0] {
		SEL_LIVE = 2'd0,
		SEL_MEM  = 2'd1,
		SEL_NONE = 2'd2
	} out_sel_t;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] cnt;
	} utf8_t;

	typedef struct packed {
		logic     cap_byte;
		logic     clr_doc;
		logic     hold_byte;
		logic     start_flush;
		logic     rd_issue;
		logic     next_pair;
		logic     load_out;
		out_sel_t sel;
		logic     little;
		logic     status;
		logic     final_flag;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic pos_is_one;
		logic bom_le;
		logic bom_be;
		logic window_full;
		logic little_ok;
		logic big_ok;
		logic trailing_odd;
		logic last_pair;
	} sts_t;

	function automatic utf8_t utf8_encode(logic [15:0] unit_in);
		logic [15:0] cu;
		utf8_t       r;
		cu = unit_in;
		if (cu >= SURR_LO && cu <= SURR_HI) begin
			cu = {8'h00, QMARK};
		end
		r = '0;
		if (cu < LIMIT_ONE) begin
			r.b0  = cu[7:0];
			r.cnt = 2'd1;
		end else if (cu < LIMIT_TWO) begin
			r.b0  = LEAD2 | {3'b000, cu[10:6]};
			r.b1  = CONT | {2'b00, cu[5:0]};
			r.cnt = 2'd2;
		end else begin
			r.b0  = LEAD3 | {4'h0, cu[15:12]};
			r.b1  = CONT | {2'b00, cu[11:6]};
			r.b2  = CONT | {2'b00, cu[5:0]};
			r.cnt = 2'd3;
		end
		return r;
	endfunction

endpackage

// ----- src/u16u8_if.sv -----
// Valid/ready channel interfaces for the transcoder's byte input and result output.
// No dependencies.
interface u16u8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_doc;

	modport source (output valid, output in_byte, output end_of_doc, input ready);
	modport sink   (input valid, input in_byte, input end_of_doc, output ready);
endinterface

interface u16u8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic [7:0] third_byte;
	logic [1:0] byte_count;
	logic       status;
	logic       final_result;

	modport source (output valid, output first_byte, output second_byte, output third_byte,
		output byte_count, output status, output final_result, input ready);
	modport sink   (input valid, input first_byte, input second_byte, input third_byte,
		input byte_count, input status, input final_result, output ready);
endinterface

// ----- src/u16u8_datapath.sv -----
// Datapath: head-buffer memory, zero counters, byte holding registers, encoder and
// output register. Depends on u16u8_pkg; driven by u16u8_ctrl commands.
module u16u8_datapath #(
	parameter int unsigned HEAD_WINDOW = u16u8_pkg::DEF_HEAD_WINDOW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  u16u8_pkg::cmd_t   cmd,
	output u16u8_pkg::sts_t   sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        first_byte,
	output logic [7:0]        second_byte,
	output logic [7:0]        third_byte,
	output logic [1:0]        byte_count,
	output logic              status,
	output logic              final_result
);

	localparam int unsigned DEPTH  = HEAD_WINDOW / 2;
	localparam int unsigned POS_W  = $clog2(HEAD_WINDOW + 1);
	localparam int unsigned PAIR_W = $clog2(DEPTH + 1);
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic [POS_W-1:0]  pos_q, pos_n;
	logic [PAIR_W-1:0] ze_q, zo_q, ze_n, zo_n, pairs_n, pairs_q;
	logic [ADDR_W-1:0] idx_q;
	logic [7:0]        prev_q, held_q;
	logic [15:0]       mem [DEPTH];
	logic [15:0]       rd_q;
	logic              out_valid_q;
	logic [PAIR_W+1:0] zo_x4, ze_x4, pairs_x3;
	logic [7:0]        unit_first, unit_second;
	logic [15:0]       unit;
	u16u8_pkg::utf8_t  enc;

	// running head statistics including the byte now on the input
	always_comb begin
		pos_n    = pos_q + 1'b1;
		ze_n     = ze_q + PAIR_W'(pos_q[0] && prev_q == 8'h00);
		zo_n     = zo_q + PAIR_W'(pos_q[0] && in_byte == 8'h00);
		pairs_n  = PAIR_W'(pos_n >> 1);
		zo_x4    = {zo_n, 2'b00};
		ze_x4    = {ze_n, 2'b00};
		pairs_x3 = {2'b00, pairs_n} + {1'b0, pairs_n, 1'b0};
	end

	always_comb begin
		sts.out_free     = !out_valid_q || out_ready;
		sts.pos_is_one   = pos_q == POS_W'(1);
		sts.bom_le       = prev_q == u16u8_pkg::BOM_FF && in_byte == u16u8_pkg::BOM_FE;
		sts.bom_be       = prev_q == u16u8_pkg::BOM_FE && in_byte == u16u8_pkg::BOM_FF;
		sts.window_full  = pos_n == POS_W'(HEAD_WINDOW);
		sts.little_ok    = pairs_n >= PAIR_W'(u16u8_pkg::MIN_PAIRS) && zo_x4 >= pairs_x3;
		sts.big_ok       = pairs_n >= PAIR_W'(u16u8_pkg::MIN_PAIRS) && ze_x4 >= pairs_x3;
		sts.trailing_odd = pos_n[0];
		sts.last_pair    = (PAIR_W'(idx_q) + 1'b1) == pairs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			ze_q        <= '0;
			zo_q        <= '0;
			pairs_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_doc) begin
				pos_q <= '0;
				ze_q  <= '0;
				zo_q  <= '0;
			end else if (cmd.cap_byte) begin
				pos_q <= pos_n;
				ze_q  <= ze_n;
				zo_q  <= zo_n;
			end
			if (cmd.start_flush) begin
				pairs_q <= pairs_n;
				idx_q   <= '0;
			end else if (cmd.next_pair) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// head pairs are written as one word at each odd position
	always_ff @(posedge clk) begin
		if (cmd.cap_byte) begin
			prev_q <= in_byte;
		end
		if (cmd.cap_byte && pos_q[0]) begin
			mem[pos_q[ADDR_W:1]] <= {prev_q, in_byte};
		end
		if (cmd.rd_issue) begin
			rd_q <= mem[idx_q];
		end
		if (cmd.hold_byte) begin
			held_q <= in_byte;
		end
	end

	always_comb begin
		case (cmd.sel)
			u16u8_pkg::SEL_MEM: begin
				unit_first  = rd_q[15:8];
				unit_second = rd_q[7:0];
			end
			default: begin
				unit_first  = held_q;
				unit_second = in_byte;
			end
		endcase
		unit = cmd.little ? {unit_second, unit_first} : {unit_first, unit_second};
		enc  = u16u8_pkg::utf8_encode(unit);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd.sel == u16u8_pkg::SEL_NONE) begin
				first_byte  <= 8'h00;
				second_byte <= 8'h00;
				third_byte  <= 8'h00;
				byte_count  <= 2'd0;
			end else begin
				first_byte  <= enc.b0;
				second_byte <= enc.b1;
				third_byte  <= enc.b2;
				byte_count  <= enc.cnt;
			end
			status       <= cmd.status;
			final_result <= cmd.final_flag;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/u16u8_ctrl.sv -----
// Controller: byte-order decision, unit pairing and head-flush sequencing.
// Depends on u16u8_pkg; commands u16u8_datapath.
module u16u8_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_end,
	output logic            in_ready,
	input  u16u8_pkg::sts_t sts,
	output u16u8_pkg::cmd_t cmd
);

	u16u8_pkg::state_t state_q, state_d;
	u16u8_pkg::order_t order_q, order_d;
	logic              parity_q, parity_d;
	logic              end_q, end_d;
	logic              acc;

	assign in_ready = state_q == u16u8_pkg::ST_RUN && sts.out_free;
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd        = '0;
		cmd.sel    = u16u8_pkg::SEL_NONE;
		cmd.little = order_q == u16u8_pkg::ORD_LITTLE;
		state_d    = state_q;
		order_d    = order_q;
		parity_d   = parity_q;
		end_d      = end_q;

		unique case (state_q)
			u16u8_pkg::ST_RUN: begin
				if (acc) begin
					unique case (order_q) inside
						u16u8_pkg::ORD_UNDECIDED: begin
							cmd.cap_byte = 1'b1;
							if (sts.pos_is_one && (sts.bom_le || sts.bom_be)) begin
								order_d  = sts.bom_le ? u16u8_pkg::ORD_LITTLE
									: u16u8_pkg::ORD_BIG;
								parity_d = 1'b0;
								if (in_end) begin
									cmd.load_out   = 1'b1;
									cmd.final_flag = 1'b1;
									cmd.clr_doc    = 1'b1;
									order_d        = u16u8_pkg::ORD_UNDECIDED;
								end
							end else if (sts.window_full || in_end) begin
								if (sts.little_ok || sts.big_ok) begin
									order_d         = sts.little_ok ? u16u8_pkg::ORD_LITTLE
										: u16u8_pkg::ORD_BIG;
									cmd.start_flush = 1'b1;
									cmd.clr_doc     = 1'b1;
									cmd.hold_byte   = 1'b1;
									parity_d        = sts.trailing_odd && !in_end;
									end_d           = in_end;
									state_d         = u16u8_pkg::ST_FRD;
								end else begin
									cmd.load_out   = 1'b1;
									cmd.status     = 1'b1;
									cmd.final_flag = in_end;
									cmd.clr_doc    = in_end;
									order_d        = in_end ? u16u8_pkg::ORD_UNDECIDED
										: u16u8_pkg::ORD_NOT16;
								end
							end
						end
						u16u8_pkg::ORD_NOT16: begin
							if (in_end) begin
								cmd.load_out   = 1'b1;
								cmd.status     = 1'b1;
								cmd.final_flag = 1'b1;
								cmd.clr_doc    = 1'b1;
								order_d        = u16u8_pkg::ORD_UNDECIDED;
							end
						end
						u16u8_pkg::ORD_LITTLE, u16u8_pkg::ORD_BIG: begin
							if (parity_q) begin
								cmd.load_out = 1'b1;
								cmd.sel      = u16u8_pkg::SEL_LIVE;
								parity_d     = 1'b0;
							end else begin
								cmd.hold_byte = 1'b1;
								parity_d      = 1'b1;
							end
							if (in_end) begin
								cmd.load_out   = 1'b1;
								cmd.final_flag = 1'b1;
								cmd.clr_doc    = 1'b1;
								order_d        = u16u8_pkg::ORD_UNDECIDED;
								parity_d       = 1'b0;
							end
						end
					endcase
				end
			end
			u16u8_pkg::ST_FRD: begin
				cmd.rd_issue = 1'b1;
				state_d      = u16u8_pkg::ST_FOUT;
			end
			u16u8_pkg::ST_FOUT: begin
				if (sts.out_free) begin
					cmd.load_out   = 1'b1;
					cmd.sel        = u16u8_pkg::SEL_MEM;
					cmd.final_flag = end_q && sts.last_pair;
					if (sts.last_pair) begin
						state_d = u16u8_pkg::ST_RUN;
						if (end_q) begin
							order_d  = u16u8_pkg::ORD_UNDECIDED;
							parity_d = 1'b0;
							end_d    = 1'b0;
						end
					end else begin
						cmd.next_pair = 1'b1;
						state_d       = u16u8_pkg::ST_FRD;
					end
				end
			end
			default: begin
				state_d = u16u8_pkg::ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= u16u8_pkg::ST_RUN;
			order_q  <= u16u8_pkg::ORD_UNDECIDED;
			parity_q <= 1'b0;
			end_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			order_q  <= order_d;
			parity_q <= parity_d;
			end_q    <= end_d;
		end
	end

endmodule

// ----- src/utf16_to_utf8_transcoder.sv -----
// Top level of the UTF-16 to UTF-8 transcoder: controller plus datapath.
// Depends on u16u8_pkg, u16u8_if, u16u8_ctrl and u16u8_datapath.
//
// Takes a document one byte per transaction, end_of_doc set on its last byte,
// and returns one result transaction per 16-bit unit holding its UTF-8 form
// (byte_count 1 to 3; surrogate halves come out as '?'). A leading FF FE or
// FE FF mark selects little or big endian and is dropped. Without a mark the
// first HEAD_WINDOW bytes are held in an on-chip head buffer of HEAD_WINDOW/2
// 16-bit words while zero bytes at even and odd positions are counted; once
// the window fills or the document ends, four or more pairs with zeros in at
// least 3/4 of them at odd (little) or even (big) positions decide the order,
// otherwise a status=1 result says the document is not UTF-16 and the rest
// of it is swallowed up to a status=1 final result. The last result of a
// document carries final_result; if the final byte produces nothing, an
// empty result (byte_count 0) is sent for it. A lone trailing byte is dropped.
// Rate: while streaming, one byte is taken per clock, stalled only while the
// single output register is full and not being drained. When the order is
// decided from the head buffer, input is held off while the buffered pairs
// are replayed through the buffer's one read port, once per document: each
// pair is read, then loaded into the output register. No clearing pass
// follows reset.
module utf16_to_utf8_transcoder #(
	parameter int unsigned HEAD_WINDOW = u16u8_pkg::DEF_HEAD_WINDOW
) (
	input logic         clk,
	input logic         arst_n,
	u16u8_in_if.sink    in_ch,
	u16u8_out_if.source out_ch
);

	u16u8_pkg::cmd_t cmd;
	u16u8_pkg::sts_t sts;

	// sequencing: order decision, unit pairing, head replay
	u16u8_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_end   (in_ch.end_of_doc),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// head buffer, counters, encoder and the output register
	u16u8_datapath #(
		.HEAD_WINDOW (HEAD_WINDOW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_ch.in_byte),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.first_byte   (out_ch.first_byte),
		.second_byte  (out_ch.second_byte),
		.third_byte   (out_ch.third_byte),
		.byte_count   (out_ch.byte_count),
		.status       (out_ch.status),
		.final_result (out_ch.final_result)
	);

endmodule
